[rtl/ati_pkg.sv]
`timescale 1ns / 1ps

package ati_pkg;

    // table geometry
    localparam int TABLE_ROWS = 64;
    localparam int IDX_W      = $clog2(TABLE_ROWS);
    localparam int CNT_W      = $clog2(TABLE_ROWS + 1);

    // field widths
    localparam int ROW_W  = 6;
    localparam int PRES_W = 27;
    localparam int ALT_W  = 32;

    // interpolation datapath
    localparam int WIDE_W    = ALT_W + 1;          // signed differences
    localparam int PROD_W    = 2 * WIDE_W;         // product magnitude
    localparam int QUO_W     = 34;                 // quotient bits kept
    localparam int SUM_W     = QUO_W + 2;          // y0 +/- quotient
    localparam int DIV_STEPS = QUO_W / 2;          // two quotient bits per cycle
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int MUL_LO_W  = 16;
    localparam int MUL_HI_W  = WIDE_W - MUL_LO_W;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // func codes
    localparam logic [1:0] FUNC_WRITE        = 2'd0;
    localparam logic [1:0] FUNC_ALT_FOR_PRES = 2'd1;
    localparam logic [1:0] FUNC_PRES_FOR_ALT = 2'd2;

    // clamp_status codes
    localparam logic [1:0] ST_INTERP      = 2'd0;
    localparam logic [1:0] ST_CLAMP_FIRST = 2'd1;
    localparam logic [1:0] ST_CLAMP_LAST  = 2'd2;

    // saturation bounds
    localparam logic signed [SUM_W-1:0] ALT_MAX_S =
        {{(SUM_W - ALT_W + 1){1'b0}}, {(ALT_W - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ALT_MIN_S =
        {{(SUM_W - ALT_W + 1){1'b1}}, {(ALT_W - 1){1'b0}}};
    localparam logic signed [SUM_W-1:0] PRES_MAX_S =
        {{(SUM_W - PRES_W){1'b0}}, {PRES_W{1'b1}}};
    localparam logic signed [SUM_W-1:0] PRES_MIN_S = '0;

    typedef struct packed {
        logic [1:0]              func;
        logic [ROW_W-1:0]        row_index;
        logic [PRES_W-1:0]       pressure;
        logic signed [ALT_W-1:0] altitude;
    } query_t;

    typedef struct packed {
        logic signed [ALT_W-1:0] out_altitude;
        logic [PRES_W-1:0]       out_pressure;
        logic [1:0]              clamp_status;
    } result_t;

    typedef struct packed {
        logic [PRES_W-1:0]       pressure;
        logic signed [ALT_W-1:0] altitude;
    } row_t;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_ALT,
        OP_PRES
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [IDX_W-1:0]        row;
        logic [PRES_W-1:0]       pressure;
        logic signed [ALT_W-1:0] altitude;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_head_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_PROBE,
        B_CMP,
        B_FETCH_A,
        B_FETCH_B,
        B_DIFF,
        B_MUL_LO,
        B_MUL_HI,
        B_CHECK,
        B_DIV,
        B_FIX,
        B_RESULT
    } back_state_t;

    function automatic logic signed [WIDE_W-1:0] pres_wide(input logic [PRES_W-1:0] p);
        return $signed({{(WIDE_W - PRES_W){1'b0}}, p});
    endfunction

    function automatic logic signed [WIDE_W-1:0] alt_wide(input logic signed [ALT_W-1:0] a);
        return $signed({{(WIDE_W - ALT_W){a[ALT_W-1]}}, a});
    endfunction

    function automatic logic [WIDE_W-1:0] mag(input logic signed [WIDE_W-1:0] v);
        logic [WIDE_W-1:0] u;
        u = v;
        return u[WIDE_W-1] ? (~u + WIDE_W'(1)) : u;
    endfunction

endpackage

[rtl/ati_ram.sv]
`timescale 1ns / 1ps

module ati_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/ati_front.sv]
`timescale 1ns / 1ps

module ati_front
    import ati_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      query_valid,
    output logic      query_stall,
    input  query_t    query,
    input  logic      pop,
    output cmd_head_t head
);

    cmd_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    cmd_t              cmd_in;
    logic              keep;
    logic              push;
    logic              do_pop;

    // classify: writes beyond the table and unused func codes are dropped
    always_comb
    begin
        cmd_in.row      = IDX_W'(query.row_index);
        cmd_in.pressure = query.pressure;
        cmd_in.altitude = query.altitude;
        cmd_in.op       = OP_WRITE;
        keep            = 1'b0;
        unique case (query.func)
            FUNC_WRITE:
            begin
                cmd_in.op = OP_WRITE;
                keep      = (32'(query.row_index) < 32'(TABLE_ROWS));
            end
            FUNC_ALT_FOR_PRES:
            begin
                cmd_in.op = OP_ALT;
                keep      = 1'b1;
            end
            FUNC_PRES_FOR_ALT:
            begin
                cmd_in.op = OP_PRES;
                keep      = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign query_stall = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign push        = query_valid && !query_stall && keep;
    assign do_pop      = pop && (cnt_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        cnt_next = cnt_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    assign head.valid = (cnt_reg != '0);
    assign head.cmd   = q_reg[rd_ptr_reg];

endmodule

[rtl/ati_back.sv]
`timescale 1ns / 1ps

module ati_back
    import ati_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_head_t head,
    output logic      pop,
    output logic      result_valid,
    input  logic      result_stall,
    output result_t   result
);

    localparam int ROW_BITS = $bits(row_t);

    back_state_t state_reg, state_next;
    logic        result_valid_reg, result_valid_next;
    result_t     result_reg, result_next;

    cmd_t                     op_reg, op_next;
    logic [CNT_W-1:0]         left_reg, left_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [1:0]               status_reg, status_next;
    logic [IDX_W-1:0]         addr_a_reg, addr_a_next;
    logic [IDX_W-1:0]         idx_b_reg, idx_b_next;
    row_t                     row_a_reg, row_a_next;
    logic signed [WIDE_W-1:0] y0_reg, y0_next;
    logic [WIDE_W-1:0]        den_reg, den_next;
    logic [WIDE_W-1:0]        dy_reg, dy_next;
    logic [WIDE_W-1:0]        dx_reg, dx_next;
    logic                     q_neg_reg, q_neg_next;
    logic                     ovf_reg, ovf_next;
    logic [PROD_W-1:0]        prod_reg, prod_next;
    logic [WIDE_W-1:0]        rem_reg, rem_next;
    logic [QUO_W-1:0]         dvd_reg, dvd_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]     iter_reg, iter_next;
    logic [ALT_W-1:0]         res_reg, res_next;

    // table RAM
    logic                wr_en;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [ROW_BITS-1:0] rd_word;
    row_t                rd_row;
    row_t                wr_row;

    // combinational temporaries
    logic [CNT_W-1:0]          step;
    logic [CNT_W-1:0]          probe;
    logic                      go_right;
    logic signed [WIDE_W-1:0]  x0, x1, y0w, y1, xw;
    logic signed [WIDE_W-1:0]  den_s, dy_s, dx_s;
    logic [MUL_HI_W-1:0]       mul_b;
    logic [WIDE_W+MUL_HI_W-1:0] mul_p;
    logic [PROD_W-QUO_W-1:0]   num_hi;
    logic [WIDE_W:0]           t1, t2;
    logic                      qb1, qb2;
    logic signed [SUM_W-1:0]   q_s, sum, lo_b, hi_b, clamped;
    logic                      out_free;

    assign wr_row.pressure = head.cmd.pressure;
    assign wr_row.altitude = head.cmd.altitude;
    assign rd_row          = rd_word;

    ati_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (TABLE_ROWS)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (head.cmd.row),
        .wr_data (wr_row),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_word)
    );

    // search probe and compare
    always_comb
    begin
        step  = count_reg >> 1;
        probe = left_reg + step;
        if (op_reg.op == OP_ALT)
        begin
            go_right = (rd_row.pressure <= op_reg.pressure);
        end
        else
        begin
            go_right = (rd_row.altitude >= op_reg.altitude);
        end
    end

    // interval operands; row_a is the row below the search result
    always_comb
    begin
        if (op_reg.op == OP_ALT)
        begin
            x0  = pres_wide(row_a_reg.pressure);
            x1  = pres_wide(rd_row.pressure);
            y0w = alt_wide(row_a_reg.altitude);
            y1  = alt_wide(rd_row.altitude);
            xw  = pres_wide(op_reg.pressure);
        end
        else
        begin
            x0  = alt_wide(rd_row.altitude);
            x1  = alt_wide(row_a_reg.altitude);
            y0w = pres_wide(rd_row.pressure);
            y1  = pres_wide(row_a_reg.pressure);
            xw  = alt_wide(op_reg.altitude);
        end
        den_s = x1 - x0;
        dy_s  = y1 - y0w;
        dx_s  = xw - x0;
    end

    // one shared 33x17 multiplier, two passes
    always_comb
    begin
        if (state_reg == B_MUL_LO)
        begin
            mul_b = MUL_HI_W'(dx_reg[MUL_LO_W-1:0]);
        end
        else
        begin
            mul_b = dx_reg[WIDE_W-1:MUL_LO_W];
        end
        mul_p = (WIDE_W + MUL_HI_W)'(dy_reg) * (WIDE_W + MUL_HI_W)'(mul_b);
    end

    // restoring divider, two quotient bits per cycle
    always_comb
    begin
        qb1 = 1'b0;
        qb2 = 1'b0;
        t1  = {rem_reg, dvd_reg[QUO_W-1]};
        if (t1 >= {1'b0, den_reg})
        begin
            t1  = t1 - {1'b0, den_reg};
            qb1 = 1'b1;
        end
        t2 = {t1[WIDE_W-1:0], dvd_reg[QUO_W-2]};
        if (t2 >= {1'b0, den_reg})
        begin
            t2  = t2 - {1'b0, den_reg};
            qb2 = 1'b1;
        end
    end

    // final add and saturation
    always_comb
    begin
        num_hi = prod_reg[PROD_W-1:QUO_W];
        q_s    = $signed({2'b00, quo_reg});
        if (q_neg_reg)
        begin
            q_s = -q_s;
        end
        sum = SUM_W'(y0_reg) + q_s;
        if (op_reg.op == OP_ALT)
        begin
            lo_b = ALT_MIN_S;
            hi_b = ALT_MAX_S;
        end
        else
        begin
            lo_b = PRES_MIN_S;
            hi_b = PRES_MAX_S;
        end
        priority if (ovf_reg)
        begin
            clamped = q_neg_reg ? lo_b : hi_b;
        end
        else if (sum < lo_b)
        begin
            clamped = lo_b;
        end
        else if (sum > hi_b)
        begin
            clamped = hi_b;
        end
        else
        begin
            clamped = sum;
        end
    end

    assign out_free = !result_valid_reg || !result_stall;

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        op_next           = op_reg;
        left_next         = left_reg;
        count_next        = count_reg;
        status_next       = status_reg;
        addr_a_next       = addr_a_reg;
        idx_b_next        = idx_b_reg;
        row_a_next        = row_a_reg;
        y0_next           = y0_reg;
        den_next          = den_reg;
        dy_next           = dy_reg;
        dx_next           = dx_reg;
        q_neg_next        = q_neg_reg;
        ovf_next          = ovf_reg;
        prod_next         = prod_reg;
        rem_next          = rem_reg;
        dvd_next          = dvd_reg;
        quo_next          = quo_reg;
        iter_next         = iter_reg;
        res_next          = res_reg;
        pop               = 1'b0;
        wr_en             = 1'b0;
        rd_en             = 1'b0;
        rd_addr           = addr_a_reg;

        unique case (state_reg)
            B_IDLE:
            begin
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.cmd.op == OP_WRITE)
                    begin
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        op_next    = head.cmd;
                        left_next  = '0;
                        count_next = CNT_W'(TABLE_ROWS);
                        state_next = B_PROBE;
                    end
                end
            end
            B_PROBE:
            begin
                rd_en      = 1'b1;
                rd_addr    = probe[IDX_W-1:0];
                state_next = B_CMP;
            end
            B_CMP:
            begin
                if (go_right)
                begin
                    left_next  = probe + CNT_W'(1);
                    count_next = count_reg - step - CNT_W'(1);
                end
                else
                begin
                    count_next = step;
                end
                if (count_next == '0)
                begin
                    state_next = B_FETCH_A;
                    priority if (left_next == '0)
                    begin
                        status_next = ST_CLAMP_FIRST;
                        addr_a_next = '0;
                    end
                    else if (left_next == CNT_W'(TABLE_ROWS))
                    begin
                        status_next = ST_CLAMP_LAST;
                        addr_a_next = IDX_W'(TABLE_ROWS - 1);
                    end
                    else
                    begin
                        status_next = ST_INTERP;
                        addr_a_next = IDX_W'(left_next - CNT_W'(1));
                        idx_b_next  = left_next[IDX_W-1:0];
                    end
                end
                else
                begin
                    state_next = B_PROBE;
                end
            end
            B_FETCH_A:
            begin
                rd_en      = 1'b1;
                rd_addr    = addr_a_reg;
                state_next = B_FETCH_B;
            end
            B_FETCH_B:
            begin
                row_a_next = rd_row;
                if (status_reg != ST_INTERP)
                begin
                    if (op_reg.op == OP_ALT)
                    begin
                        res_next = rd_row.altitude;
                    end
                    else
                    begin
                        res_next = ALT_W'(rd_row.pressure);
                    end
                    state_next = B_RESULT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_b_reg;
                    state_next = B_DIFF;
                end
            end
            B_DIFF:
            begin
                y0_next    = y0w;
                den_next   = mag(den_s);
                dy_next    = mag(dy_s);
                dx_next    = mag(dx_s);
                q_neg_next = den_s[WIDE_W-1] ^ dy_s[WIDE_W-1] ^ dx_s[WIDE_W-1];
                state_next = B_MUL_LO;
            end
            B_MUL_LO:
            begin
                prod_next  = PROD_W'(mul_p);
                state_next = B_MUL_HI;
            end
            B_MUL_HI:
            begin
                prod_next  = prod_reg + (PROD_W'(mul_p) << MUL_LO_W);
                state_next = B_CHECK;
            end
            B_CHECK:
            begin
                quo_next = '0;
                ovf_next = 1'b0;
                priority if (den_reg == '0)
                begin
                    // equal arguments in both rows: result is the lower row's value
                    state_next = B_FIX;
                end
                else if (WIDE_W'(num_hi) >= den_reg)
                begin
                    // quotient too large for any field: saturate
                    ovf_next   = 1'b1;
                    state_next = B_FIX;
                end
                else
                begin
                    rem_next   = WIDE_W'(num_hi);
                    dvd_next   = prod_reg[QUO_W-1:0];
                    iter_next  = DIV_CNT_W'(DIV_STEPS - 1);
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                rem_next  = t2[WIDE_W-1:0];
                dvd_next  = dvd_reg << 2;
                quo_next  = {quo_reg[QUO_W-3:0], qb1, qb2};
                iter_next = iter_reg - DIV_CNT_W'(1);
                if (iter_reg == '0)
                begin
                    state_next = B_FIX;
                end
            end
            B_FIX:
            begin
                res_next   = clamped[ALT_W-1:0];
                state_next = B_RESULT;
            end
            B_RESULT:
            begin
                if (out_free)
                begin
                    result_valid_next        = 1'b1;
                    result_next.clamp_status = status_reg;
                    if (op_reg.op == OP_ALT)
                    begin
                        result_next.out_altitude = res_reg;
                        result_next.out_pressure = op_reg.pressure;
                    end
                    else
                    begin
                        result_next.out_altitude = op_reg.altitude;
                        result_next.out_pressure = res_reg[PRES_W-1:0];
                    end
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= B_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        op_reg     <= op_next;
        left_reg   <= left_next;
        count_reg  <= count_next;
        status_reg <= status_next;
        addr_a_reg <= addr_a_next;
        idx_b_reg  <= idx_b_next;
        row_a_reg  <= row_a_next;
        y0_reg     <= y0_next;
        den_reg    <= den_next;
        dy_reg     <= dy_next;
        dx_reg     <= dx_next;
        q_neg_reg  <= q_neg_next;
        ovf_reg    <= ovf_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        quo_reg    <= quo_next;
        iter_reg   <= iter_next;
        res_reg    <= res_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

[rtl/atmosphere_table_interpolator_unit.sv]
// Standard-atmosphere table interpolator. Holds TABLE_ROWS rows of {pressure in mPa,
// altitude in mm}, pressure rising and altitude falling with row index, and converts
// either way. func 0 writes one row (no result); func 1 returns the altitude for a
// pressure (upper-bound binary search on pressure), func 2 the pressure for an
// altitude (descending upper-bound search on altitude). Between rows the result is
// linear interpolation with division truncating toward zero; arguments past either end
// return the first or last row with clamp_status 1 or 2, and an interpolated value
// outside its field saturates. Writes to rows beyond the table and func 3 are accepted
// and dropped. Rows are undefined until written. Items are accepted into a two-entry
// queue and carried out one at a time, in order. A write is done when it reaches the
// head of the queue. A query runs search probes, log2(TABLE_ROWS)+1 at most, then
// fetches the bracketing rows, multiplies in two passes, runs the divider (two quotient
// bits a cycle) and finishes; a clamped query skips the multiply and divider. The single
// read port of the table RAM sets the search time and the divider sets the rest. A
// finished result waits in the output register while the next item is already being
// worked on.
`timescale 1ns / 1ps

module atmosphere_table_interpolator_unit
    import ati_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    query_valid,
    output logic    query_stall,
    input  query_t  query,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    // head of the command queue, and its pop strobe from the back end
    cmd_head_t head;
    logic      pop;

    // front end: accept, decode func, drop no-op items, queue the rest
    ati_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .query_valid (query_valid),
        .query_stall (query_stall),
        .query       (query),
        .pop         (pop),
        .head        (head)
    );

    // back end: table RAM, search, interpolation and the result register
    ati_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

[rtl/ati_checker.sv]
`timescale 1ns / 1ps

module ati_checker
    import ati_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    query_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // stalled result stays offered
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // stalled result payload holds
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

    // a reset cycle leaves the queue empty and no stale result
    a_reset_clean: assert property (@(posedge clk)
        !rst_n |=> !result_valid && !query_stall)
        else $error("state not clean after reset");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.clamp_status == ST_INTERP ||
                          result.clamp_status == ST_CLAMP_FIRST ||
                          result.clamp_status == ST_CLAMP_LAST))
        else $error("undefined clamp status");

endmodule

bind atmosphere_table_interpolator_unit ati_checker u_ati_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .query_stall  (query_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
